@@ rtl/modbus_rtu_request_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU request parser
// Shared forms for the concurrent checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_PARSER_ASSERT_SVH
`define MODBUS_RTU_REQUEST_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrp_pkg
// Types, codes and the CRC-16/MODBUS byte step for the request parser.
// ----------------------------------------------------------------------------
package mrp_pkg;

	localparam int unsigned DATA_BYTES_DEFAULT = 256;

	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FUNC_FIRST_FIXED = 8'd1;
	localparam logic [7:0] FUNC_LAST_FIXED  = 8'd6;
	localparam logic [7:0] FUNC_WRITE_MULTI = 8'd16;

	localparam logic [8:0] FIXED_DATA_BYTES = 9'd4;
	localparam logic [8:0] MULTI_HEAD_BYTES = 9'd5;

	localparam int unsigned OUT_DATA_W = 104;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FUNC,
		PH_DATA,
		PH_CRCL,
		PH_CRCH
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_UNSUP      = 3'd1,
		ST_OVER       = 3'd2,
		ST_CRCERR     = 3'd3,
		ST_INCOMPLETE = 3'd4
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic        frame_done;
		logic [7:0]  held_address;
		logic [7:0]  held_function;
		logic [15:0] running_crc;
		logic [7:0]  crc_low_byte;
		logic [8:0]  bytes_taken;
		logic [8:0]  bytes_expected;
		logic [15:0] word_zero;
		logic [15:0] word_one;
		logic [7:0]  count_byte;
	} frame_state_t;

	localparam frame_state_t FRAME_CLEAR = '{
		phase:          PH_IDLE,
		frame_done:     1'b0,
		held_address:   8'h00,
		held_function:  8'h00,
		running_crc:    CRC_SEED,
		crc_low_byte:   8'h00,
		bytes_taken:    9'd0,
		bytes_expected: 9'd0,
		word_zero:      16'h0000,
		word_one:       16'h0000,
		count_byte:     8'h00
	};

	// One byte of CRC-16/MODBUS, reflected polynomial, LSB first.
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/modbus_rtu_request_parser.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_request_parser
// Parses Modbus RTU request frames byte by byte and reports at most once per frame.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Content
// s_*       in         s_tvalid / s_tready   one received byte with frame marks
// m_*       out        m_tvalid / m_tready   one report per frame
// cfg_*     in         cfg_valid / cfg_ready slave address register write
//
// Each byte passes an input register and then the parse logic, whose report
// is written to the result register once the byte leaves the input register;
// it is then offered on m_*.
// One byte is accepted in every cycle while the report path does not stall; the
// byte-wide CRC step and the frame state update are both done in the parse logic.
// A stalled report holds the pipeline; the input register still accepts a
// byte while its stage is empty. Reset is asynchronous and clears the frame
// state, the pipeline valids and sets the slave address to 1.
//
`include "modbus_rtu_request_parser_assert.svh"

module modbus_rtu_request_parser #(
	parameter int unsigned DATA_BYTES = mrp_pkg::DATA_BYTES_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Received bytes.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] data_byte
	input  logic                               s_tuser,   // [0] first_of_frame
	input  logic                               s_tlast,   // last_of_frame
	// Frame reports.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] status, [10:3] frame_address, [18:11] function_byte,
	// [27:19] data_count, [43:28] first_word, [59:44] second_word,
	// [67:60] payload_byte_count, [83:68] received_crc, [99:84] computed_crc,
	// [103:100] zero
	output logic [mrp_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Slave address register.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [7:0]                         cfg_data
);

	import mrp_pkg::*;

	// Configuration register. Writes are always taken.
	logic [7:0] own_addr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= 8'h01;
		end else if (cfg_valid && cfg_ready) begin
			own_addr_q <= cfg_data;
		end
	end

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// The result register is free when empty or being drained this cycle.
	logic out_free;
	logic fire_s1;

	assign out_free = !m_tvalid || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// Frame state and parse logic.
	frame_state_t st_q;
	frame_state_t cur;
	frame_state_t nx;
	logic         res_valid;
	status_t      res_status;
	logic [15:0]  res_rx_crc;
	logic [8:0]   taken_inc;

	always_comb begin
		cur        = first_s1 ? FRAME_CLEAR : st_q;
		nx         = cur;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_rx_crc = 16'h0000;
		taken_inc  = cur.bytes_taken + 9'd1;
		if (!cur.frame_done) begin
			unique case (cur.phase)
				PH_IDLE: begin
					if (byte_s1 == own_addr_q) begin
						nx.held_address = byte_s1;
						nx.running_crc  = crc16_step(CRC_SEED, byte_s1);
						nx.phase        = PH_FUNC;
					end
				end
				PH_FUNC: begin
					nx.held_function = byte_s1;
					nx.running_crc   = crc16_step(cur.running_crc, byte_s1);
					nx.bytes_taken   = 9'd0;
					if (byte_s1 >= FUNC_FIRST_FIXED && byte_s1 <= FUNC_LAST_FIXED) begin
						nx.bytes_expected = FIXED_DATA_BYTES;
						nx.phase          = PH_DATA;
					end else if (byte_s1 == FUNC_WRITE_MULTI) begin
						nx.bytes_expected = MULTI_HEAD_BYTES;
						nx.phase          = PH_DATA;
					end else begin
						res_valid  = 1'b1;
						res_status = ST_UNSUP;
					end
				end
				PH_DATA: begin
					if (cur.bytes_taken >= 9'(DATA_BYTES)) begin
						res_valid  = 1'b1;
						res_status = ST_OVER;
					end else begin
						case (cur.bytes_taken)
							9'd0:    nx.word_zero[15:8] = byte_s1;
							9'd1:    nx.word_zero[7:0]  = byte_s1;
							9'd2:    nx.word_one[15:8]  = byte_s1;
							9'd3:    nx.word_one[7:0]   = byte_s1;
							9'd4:    nx.count_byte      = byte_s1;
							default: nx.count_byte      = cur.count_byte;
						endcase
						nx.running_crc = crc16_step(cur.running_crc, byte_s1);
						nx.bytes_taken = taken_inc;
						// The fifth byte of a multiple write sets the payload length.
						if (cur.held_function == FUNC_WRITE_MULTI
								&& taken_inc == MULTI_HEAD_BYTES) begin
							nx.bytes_expected = {1'b0, nx.count_byte} + MULTI_HEAD_BYTES;
						end
						if (taken_inc == nx.bytes_expected) begin
							nx.phase = PH_CRCL;
						end
					end
				end
				PH_CRCL: begin
					nx.crc_low_byte = byte_s1;
					nx.phase        = PH_CRCH;
				end
				PH_CRCH: begin
					res_valid  = 1'b1;
					res_rx_crc = {byte_s1, cur.crc_low_byte};
					res_status = (res_rx_crc == cur.running_crc) ? ST_OK : ST_CRCERR;
				end
				default: begin
					nx.phase = PH_IDLE;
				end
			endcase
			// A frame that ends without a report is incomplete.
			if (!res_valid && last_s1) begin
				res_valid  = 1'b1;
				res_status = ST_INCOMPLETE;
				res_rx_crc = {8'h00, nx.crc_low_byte};
			end
			if (res_valid) begin
				nx.frame_done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FRAME_CLEAR;
		end else if (fire_s1) begin
			st_q <= nx;
		end
	end

	// Result register.
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [7:0]            payload_count;

	assign payload_count = (nx.held_function == FUNC_WRITE_MULTI) ? nx.count_byte : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= fire_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_valid) begin
			m_tdata_q <= {4'h0, nx.running_crc, res_rx_crc, payload_count, nx.word_one,
				nx.word_zero, nx.bytes_taken, nx.held_function, nx.held_address, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks.
	`MRP_ASSERT_NEXT(a_report_closes_frame, fire_s1 && res_valid, st_q.frame_done,
		"report did not close the frame")
	`MRP_ASSERT_NOW(a_quiet_after_report, fire_s1 && st_q.frame_done && !first_s1, !res_valid,
		"second report within one frame")
	`MRP_ASSERT_NOW(a_count_bounded, 1'b1, st_q.bytes_taken <= 9'(DATA_BYTES),
		"data count beyond the data limit")
	`MRP_ASSERT_NOW(a_stall_cause, !s_tready, valid_s1 && m_tvalid && !m_tready,
		"input stalled without a blocked report")

endmodule

@@ test/modbus_rtu_request_parser_tb.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_request_parser_tb
// Self-checking bench for the Modbus RTU request parser. Request frames,
// corrupted and truncated frames and stray noise are streamed in under
// several slave addresses and idling patterns. An in-bench frame model
// predicts the report, if any, of each frame, and every report the block
// gives is compared with it field by field.
// ----------------------------------------------------------------------------
module modbus_rtu_request_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrp_pkg::*;

	localparam int unsigned DATA_BYTES  = DATA_BYTES_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Two pipeline stages between an accepted item and its report; a little
	// margin is added wherever the bench waits for the block to settle.
	localparam int unsigned SETTLE_CYCLES = 6;

	// One frame report, unpacked from the output item.
	typedef struct {
		status_t     status;
		logic [7:0]  address;
		logic [7:0]  func;
		logic [8:0]  count;
		logic [15:0] word0;
		logic [15:0] word1;
		logic [7:0]  byte_count;
		logic [15:0] rx_crc;
		logic [15:0] calc_crc;
	} report_t;

	// Frame model: follows the parser byte by byte and keeps the reports it
	// owes, oldest first.
	class frame_report_model;
		logic [7:0]  own_addr;
		phase_t      ph;
		bit          reported;
		logic [7:0]  addr;
		logic [7:0]  func;
		logic [15:0] crc;
		logic [7:0]  crc_lo;
		logic [8:0]  taken;
		logic [8:0]  wanted;
		logic [15:0] word0;
		logic [15:0] word1;
		logic [7:0]  pay_count;
		report_t     pending_reports[$];
		int unsigned bytes_used;
		int unsigned reports_seen;
		int unsigned errors;
		int unsigned status_seen[5];

		function new();
			own_addr = 8'h01;
			clear_frame();
		endfunction

		// CRC-16/MODBUS, one data bit at a time, least significant bit first.
		static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
			bit fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = c >> 1;
				if (fb)
					c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function void clear_frame();
			ph        = PH_IDLE;
			reported  = 1'b0;
			addr      = 8'h00;
			func      = 8'h00;
			crc       = CRC_SEED;
			crc_lo    = 8'h00;
			taken     = 9'd0;
			wanted    = 9'd0;
			word0     = 16'h0000;
			word1     = 16'h0000;
			pay_count = 8'h00;
		endfunction

		function void file_report(status_t st, logic [15:0] rx);
			report_t r;
			r.status     = st;
			r.address    = addr;
			r.func       = func;
			r.count      = taken;
			r.word0      = word0;
			r.word1      = word1;
			r.byte_count = (func == FUNC_WRITE_MULTI) ? pay_count : 8'h00;
			r.rx_crc     = rx;
			r.calc_crc   = crc;
			pending_reports.push_back(r);
			reported = 1'b1;
		endfunction

		// Called for every accepted input item.
		function void note_byte(logic [7:0] b, bit first, bit last);
			if (first)
				clear_frame();
			// Once a frame has reported, the rest of it is dropped.
			if (reported)
				return;
			bytes_used++;
			case (ph)
				PH_IDLE: begin
					if (b == own_addr) begin
						addr = b;
						crc  = crc_byte(CRC_SEED, b);
						ph   = PH_FUNC;
					end
				end
				PH_FUNC: begin
					func  = b;
					crc   = crc_byte(crc, b);
					taken = 9'd0;
					if (b >= FUNC_FIRST_FIXED && b <= FUNC_LAST_FIXED) begin
						wanted = FIXED_DATA_BYTES;
					end else if (b == FUNC_WRITE_MULTI) begin
						wanted = MULTI_HEAD_BYTES;
					end else begin
						file_report(ST_UNSUP, 16'h0000);
						return;
					end
					ph = PH_DATA;
				end
				PH_DATA: begin
					// The byte that would exceed the data buffer is neither
					// counted nor folded into the CRC.
					if (taken >= DATA_BYTES) begin
						file_report(ST_OVER, 16'h0000);
						return;
					end
					case (taken)
						9'd0: word0[15:8] = b;
						9'd1: word0[7:0]  = b;
						9'd2: word1[15:8] = b;
						9'd3: word1[7:0]  = b;
						9'd4: pay_count   = b;
						default: ;
					endcase
					crc   = crc_byte(crc, b);
					taken = taken + 9'd1;
					if (func == FUNC_WRITE_MULTI && taken == MULTI_HEAD_BYTES)
						wanted = {1'b0, pay_count} + MULTI_HEAD_BYTES;
					if (taken == wanted)
						ph = PH_CRCL;
				end
				PH_CRCL: begin
					crc_lo = b;
					ph     = PH_CRCH;
				end
				default: begin
					file_report(({b, crc_lo} == crc) ? ST_OK : ST_CRCERR, {b, crc_lo});
					return;
				end
			endcase
			if (last)
				file_report(ST_INCOMPLETE, {8'h00, crc_lo});
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		// Called for every accepted output item.
		function void check_report(logic [OUT_DATA_W-1:0] d);
			report_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected report, expected none, actual %h", $time, d);
				return;
			end
			want = pending_reports.pop_front();
			reports_seen++;
			status_seen[want.status]++;
			compare_field("status", want.status, d[2:0]);
			compare_field("frame_address", want.address, d[10:3]);
			compare_field("function_byte", want.func, d[18:11]);
			compare_field("data_count", want.count, d[27:19]);
			compare_field("first_word", want.word0, d[43:28]);
			compare_field("second_word", want.word1, d[59:44]);
			compare_field("payload_byte_count", want.byte_count, d[67:60]);
			compare_field("received_crc", want.rx_crc, d[83:68]);
			compare_field("computed_crc", want.calc_crc, d[99:84]);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] data_byte
	logic                  s_tuser;   // [0] first_of_frame
	logic                  s_tlast;   // last_of_frame
	logic                  m_tvalid;
	logic                  m_tready;
	// [2:0] status, [10:3] frame_address, [18:11] function_byte,
	// [27:19] data_count, [43:28] first_word, [59:44] second_word,
	// [67:60] payload_byte_count, [83:68] received_crc, [99:84] computed_crc
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [7:0]            cfg_data;

	frame_report_model sb = new();

	// Idling percentages of the current phase.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;

	// Frame under construction.
	logic [7:0] frame_bytes[$];

	modbus_rtu_request_parser #(
		.DATA_BYTES(DATA_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Both handshakes are observed at the rising edge; inputs only ever move
	// at the falling edge, so the values seen here are settled.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_byte(s_tdata, s_tuser, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_report(m_tdata);
	end

	// The receiver stalls at random in the phases that ask for it.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("modbus_rtu_request_parser_tb: done, errors");
		$finish;
	end

	function automatic bit chance(int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	// Entered and left just after a falling edge. The valid is driven once
	// per falling edge, so a run of back-to-back items keeps it high.
	task automatic send_byte(logic [7:0] b, bit first, bit last);
		int unsigned gaps;
		gaps = 0;
		while (gaps < 20 && chance(tx_idle_pct))
			gaps++;
		repeat (gaps) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_frame(bit mark_first, bit mark_last);
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], mark_first && i == 0,
				mark_last && i == frame_bytes.size() - 1);
	endtask

	// Builds a request: address, function, data as the function wants it,
	// then the CRC low byte first. A bad CRC is flipped in at least one bit.
	function automatic void build_request(logic [7:0] addr, logic [7:0] func,
			int unsigned payload, bit good_crc);
		logic [15:0] c;
		int unsigned n;
		frame_bytes.delete();
		frame_bytes.push_back(addr);
		frame_bytes.push_back(func);
		n = 4;
		if (func == FUNC_WRITE_MULTI)
			n = 5 + payload;
		for (int i = 0; i < n; i++)
			frame_bytes.push_back((func == FUNC_WRITE_MULTI && i == 4) ?
				8'(payload) : 8'($urandom_range(255)));
		c = CRC_SEED;
		foreach (frame_bytes[i])
			c = frame_report_model::crc_byte(c, frame_bytes[i]);
		if (!good_crc)
			c = c ^ 16'($urandom_range(65535, 1));
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endfunction

	// Mostly well-formed requests with random content; the rest is noise,
	// frames with a wrong address or function, bad CRCs, cut-short frames,
	// leading and trailing junk and frames whose first or last mark is missing.
	task automatic random_frame();
		logic [7:0] addr;
		logic [7:0] func;
		int unsigned payload;
		int unsigned pick;
		if (chance(5)) begin
			send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
			return;
		end
		addr = chance(90) ? sb.own_addr : 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 60)
			func = 8'($urandom_range(FUNC_LAST_FIXED, FUNC_FIRST_FIXED));
		else if (pick < 85)
			func = FUNC_WRITE_MULTI;
		else
			func = 8'($urandom_range(255));
		payload = chance(3) ? $urandom_range(255, 250) : $urandom_range(8);
		build_request(addr, func, payload, chance(85));
		if (chance(12))
			repeat ($urandom_range(3, 1))
				frame_bytes.push_front(8'($urandom_range(255)));
		if (chance(10))
			while (frame_bytes.size() > 1 && chance(70))
				void'(frame_bytes.pop_back());
		if (chance(10))
			repeat ($urandom_range(3, 1))
				frame_bytes.push_back(8'($urandom_range(255)));
		send_frame(!chance(5), !chance(5));
	endtask

	// One phase of random traffic. A phase may open with a maximum-length
	// write-multiple request, whose data runs past the buffer.
	task automatic run_block(int unsigned tx_pct, int unsigned rx_pct,
			int unsigned target, bit with_overflow);
		int unsigned start;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		start = sb.bytes_used;
		if (with_overflow) begin
			build_request(sb.own_addr, FUNC_WRITE_MULTI, 255, 1'b1);
			send_frame(1'b1, 1'b1);
		end
		while (sb.bytes_used - start < target)
			random_frame();
	endtask

	// The sender holds off until every owed report has come, then lets the
	// pipeline empty of items that owe nothing.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_slave_address(logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.own_addr = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		m_tready  = 1'b1;
		cfg_valid = 1'b0;
		cfg_data  = 8'h00;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening, under the reset address of 1.
		// A lone byte that never matches the address reports incomplete.
		send_byte(8'h00, 1'b1, 1'b1);
		// Function 0 is unsupported; the byte after the report is dropped.
		frame_bytes = '{8'h01, 8'h00, 8'hFF};
		send_frame(1'b1, 1'b1);
		// Highest fixed-length function with a correct CRC.
		build_request(8'h01, FUNC_LAST_FIXED, 0, 1'b1);
		send_frame(1'b1, 1'b1);
		// Write-multiple with a byte count of zero and a broken CRC.
		build_request(8'h01, FUNC_WRITE_MULTI, 0, 1'b0);
		send_frame(1'b1, 1'b1);
		// Highest function byte, unsupported, on the last item.
		frame_bytes = '{8'h01, 8'hFF};
		send_frame(1'b1, 1'b1);

		// Random phases; before each but the first, the slave address is rewritten.
		run_block(0, 0, 330, 1'b1);
		wait_idle();
		write_slave_address(8'h00);
		run_block(51, 0, 330, 1'b0);
		wait_idle();
		write_slave_address(8'hFF);
		run_block(0, 51, 330, 1'b1);
		wait_idle();
		write_slave_address(8'($urandom_range(255)));
		run_block(13, 13, 330, 1'b0);
		wait_idle();
		write_slave_address(8'($urandom_range(255)));
		run_block(0, 0, 330, 1'b1);
		wait_idle();
		write_slave_address(8'h01);
		run_block(13, 13, 330, 1'b0);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_reports.size() != 0) begin
			sb.errors++;
			$display("%0t: reports left over, expected 0, actual %0d", $time,
				sb.pending_reports.size());
		end
		$display("Run covered %0d parsed bytes and %0d frame reports under six address settings.",
			sb.bytes_used, sb.reports_seen);
		$display("Reports: ok %0d, unsupported %0d, overflow %0d, crc error %0d, incomplete %0d.",
			sb.status_seen[ST_OK], sb.status_seen[ST_UNSUP], sb.status_seen[ST_OVER],
			sb.status_seen[ST_CRCERR], sb.status_seen[ST_INCOMPLETE]);
		if (sb.errors == 0)
			$display("modbus_rtu_request_parser_tb: done, clean");
		else
			$display("modbus_rtu_request_parser_tb: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mrp_pkg.sv
rtl/modbus_rtu_request_parser.sv
test/modbus_rtu_request_parser_tb.sv
